FILE: src/wid_pkg.sv
// shared types, constants and helper functions for the watercolor ink diffusion block
package wid_pkg;

    localparam int GRID_W = 256;
    localparam int GRID_H = 256;
    localparam int CELLS  = GRID_W * GRID_H;
    localparam int X_W    = $clog2(GRID_W);
    localparam int Y_W    = $clog2(GRID_H);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int POS_W  = 8;
    localparam int XD_W   = (X_W > POS_W) ? X_W : POS_W;
    localparam int YD_W   = (Y_W > POS_W) ? Y_W : POS_W;
    localparam int DD_W   = (XD_W > YD_W) ? XD_W : YD_W;
    localparam int DIST_W = 2 * DD_W + 6;

    typedef logic [15:0]      t_q;
    typedef logic [2:0][15:0] t_rgb;

    localparam t_q SAT_MAX    = 16'hFFFF;
    localparam t_q SURF_LIMIT = 16'd819;
    localparam t_q SURF_MOVE  = 16'd123;
    localparam t_q MID_LIMIT  = 16'd410;
    localparam t_q MID_LOSS   = 16'd41;
    localparam t_q DEEP_GAIN  = 16'd20;
    localparam t_q DRY_THRESH = 16'd410;
    localparam t_q WET_THRESH = 16'd41;
    localparam logic [17:0] ONE_Q = 18'd4096;

    // item modes
    localparam logic [1:0] MODE_FRAME = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // paper modes
    localparam logic [1:0] PAPER_CROSS = 2'd0;
    localparam logic [1:0] PAPER_DIAG  = 2'd1;
    localparam logic [1:0] PAPER_ALT   = 2'd2;

    localparam logic [1:0] PEN_NONE = 2'd3;

    // register indexes
    localparam logic [2:0] REG_PEN   = 3'd0;
    localparam logic [2:0] REG_CAP   = 3'd1;
    localparam logic [2:0] REG_RXW   = 3'd2;
    localparam logic [2:0] REG_RYW   = 3'd3;
    localparam logic [2:0] REG_SIZE  = 3'd4;
    localparam logic [2:0] REG_PAPER = 3'd5;
    localparam logic [2:0] REG_WET   = 3'd6;

    typedef struct packed {
        logic [1:0] mode;
        logic       brush_down;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic [12:0] shown_red;
        logic [12:0] shown_green;
        logic [12:0] shown_blue;
    } t_out_item;

    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_INIT_FULL,
        CNT_INIT_INNER,
        CNT_STEP_FULL,
        CNT_STEP_INNER
    } t_cnt_op;

    typedef enum logic [1:0] {
        RD_HERE,
        RD_NB,
        RD_POS
    } t_rd_src;

    typedef struct packed {
        t_cnt_op    cnt_op;
        logic       load_in;
        logic       rd_en;
        t_rd_src    rd_src;
        logic [1:0] rd_nb;
        logic [1:0] wr_nb;
        logic       clr_wr;
        logic       frame;
        logic       br_pre;
        logic       br_wr;
        logic       d_lat;
        logic       d_upd;
        logic       d_fin;
        logic       res_zero;
        logic       res_load;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       paint;
        logic       full_last;
        logic       inner_last;
        logic       out_free;
    } t_stat;

    function automatic t_q sat_add(input t_q a, input t_q b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? SAT_MAX : s[15:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                   input logic [Y_W-1:0] y);
        return ADDR_W'(y) * ADDR_W'(GRID_W) + ADDR_W'(x);
    endfunction

    // neighbor order: cross right, left, down, up; diagonal (-1,-1),(-1,+1),(+1,-1),(+1,+1)
    function automatic logic [ADDR_W-1:0] nb_addr(input logic [X_W-1:0] x,
                                                 input logic [Y_W-1:0] y,
                                                 input logic diag,
                                                 input logic [1:0] idx);
        logic [X_W-1:0] nx;
        logic [Y_W-1:0] ny;
        nx = x;
        ny = y;
        if (diag) begin
            nx = idx[1] ? x + 1'b1 : x - 1'b1;
            ny = idx[0] ? y + 1'b1 : y - 1'b1;
        end else begin
            case (idx)
                2'd0: nx = x + 1'b1;
                2'd1: nx = x - 1'b1;
                2'd2: ny = y + 1'b1;
                default: ny = y - 1'b1;
            endcase
        end
        return cell_addr(nx, ny);
    endfunction

    // round(level * 20.48): level*20 + (level*24 + 25) / 50 via reciprocal
    function automatic logic [12:0] ink_amount(input logic [7:0] lvl);
        logic [12:0] r;
        logic [26:0] p;
        r = 13'(lvl) * 13'd24 + 13'd25;
        p = 27'(r) * 27'd10486;
        return 13'(lvl) * 13'd20 + 13'(p[26:19]);
    endfunction

endpackage

FILE: src/wid_ctrl.sv
// sequencing state machine for the ink diffusion block
module wid_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wid_pkg::t_stat i_stat,
    output wid_pkg::t_cmd  o_cmd
);
    import wid_pkg::*;

    typedef enum logic [12:0] {
        S_CLR    = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_DISP   = 13'b0000000000100,
        S_FRAME  = 13'b0000000001000,
        S_BR_RD  = 13'b0000000010000,
        S_BR_WR  = 13'b0000000100000,
        S_D_RDH  = 13'b0000001000000,
        S_D_LATH = 13'b0000010000000,
        S_D_UPD  = 13'b0000100000000,
        S_D_FIN  = 13'b0001000000000,
        S_RES    = 13'b0010000000000,
        S_DONE   = 13'b0100000000000,
        S_SPARE  = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       r_boot, n_boot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_k     <= 2'd0;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_boot  <= n_boot;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_k     = r_k;
        n_boot  = r_boot;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.full_last) begin
                    n_state = r_boot ? S_IDLE : S_DONE;
                    n_boot  = 1'b0;
                end else begin
                    o_cmd.cnt_op = CNT_STEP_FULL;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.res_zero = 1'b1;
                case (i_stat.mode)
                    MODE_FRAME: n_state = S_FRAME;
                    MODE_READ: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_src = RD_POS;
                        n_state      = S_RES;
                    end
                    MODE_CLEAR: begin
                        o_cmd.cnt_op = CNT_INIT_FULL;
                        n_state      = S_CLR;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_FRAME: begin
                o_cmd.frame = 1'b1;
                if (i_stat.paint) begin
                    o_cmd.cnt_op = CNT_INIT_FULL;
                    n_state      = S_BR_RD;
                end else begin
                    o_cmd.cnt_op = CNT_INIT_INNER;
                    n_state      = S_D_RDH;
                end
            end
            S_BR_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_HERE;
                o_cmd.br_pre = 1'b1;
                n_state      = S_BR_WR;
            end
            S_BR_WR: begin
                o_cmd.br_wr = 1'b1;
                if (i_stat.full_last) begin
                    o_cmd.cnt_op = CNT_INIT_INNER;
                    n_state      = S_D_RDH;
                end else begin
                    o_cmd.cnt_op = CNT_STEP_FULL;
                    n_state      = S_BR_RD;
                end
            end
            S_D_RDH: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_HERE;
                n_state      = S_D_LATH;
            end
            S_D_LATH: begin
                o_cmd.d_lat  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_NB;
                o_cmd.rd_nb  = 2'd0;
                n_k          = 2'd0;
                n_state      = S_D_UPD;
            end
            S_D_UPD: begin
                o_cmd.d_upd = 1'b1;
                o_cmd.wr_nb = r_k;
                if (r_k != 2'd3) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_NB;
                    o_cmd.rd_nb  = r_k + 2'd1;
                    n_k          = r_k + 2'd1;
                end else begin
                    n_state = S_D_FIN;
                end
            end
            S_D_FIN: begin
                o_cmd.d_fin = 1'b1;
                if (i_stat.inner_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.cnt_op = CNT_STEP_INNER;
                    n_state      = S_D_RDH;
                end
            end
            S_RES: begin
                o_cmd.res_load = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: src/wid_dp.sv
// datapath: ink layer memories, scan counters, brush and diffusion arithmetic
module wid_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wid_pkg::t_cmd      i_cmd,
    output wid_pkg::t_stat     o_stat,
    input  wid_pkg::t_in_item  i_in,
    input  logic               i_cfg_wr,
    input  logic [2:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output wid_pkg::t_out_item o_out
);
    import wid_pkg::*;

    // configuration
    logic [1:0] r_pen, r_paper;
    logic [7:0] r_cap;
    logic [4:0] r_rxw, r_ryw;
    logic [9:0] r_size;
    logic       r_wet;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen   <= 2'd0;
            r_cap   <= 8'd40;
            r_rxw   <= 5'd15;
            r_ryw   <= 5'd15;
            r_size  <= 10'd40;
            r_paper <= PAPER_ALT;
            r_wet   <= 1'b0;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                REG_PEN:   r_pen   <= i_cfg_data[1:0];
                REG_CAP:   r_cap   <= i_cfg_data[7:0];
                REG_RXW:   r_rxw   <= i_cfg_data[4:0];
                REG_RYW:   r_ryw   <= i_cfg_data[4:0];
                REG_SIZE:  r_size  <= i_cfg_data;
                REG_PAPER: r_paper <= i_cfg_data[1:0];
                REG_WET:   r_wet   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // item, ink level and pattern
    t_in_item     r_in;
    logic [7:0]   r_level;
    logic         r_diag;
    logic [19:0]  r_bound;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in;
        end
        if (i_cmd.frame) begin
            r_bound <= 20'(r_size) * 20'(r_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 8'd40;
            r_diag  <= 1'b0;
        end else if (i_cmd.frame) begin
            if (r_in.brush_down) begin
                if (r_level > 8'd1) begin
                    r_level <= r_level - 8'd1;
                end
            end else begin
                r_level <= r_cap;
            end
            case (r_paper)
                PAPER_CROSS: r_diag <= 1'b0;
                PAPER_DIAG:  r_diag <= 1'b1;
                PAPER_ALT:   r_diag <= ~r_diag;
                default:     r_diag <= r_diag;
            endcase
        end
    end

    // scan counters, y inner
    logic [X_W-1:0] r_x;
    logic [Y_W-1:0] r_y;
    logic           full_last, inner_last;

    assign full_last  = (r_x == X_W'(GRID_W - 1)) && (r_y == Y_W'(GRID_H - 1));
    assign inner_last = (r_x == X_W'(GRID_W - 2)) && (r_y == Y_W'(GRID_H - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else begin
            case (i_cmd.cnt_op)
                CNT_INIT_FULL: begin
                    r_x <= '0;
                    r_y <= '0;
                end
                CNT_INIT_INNER: begin
                    r_x <= X_W'(1);
                    r_y <= Y_W'(1);
                end
                CNT_STEP_FULL: begin
                    if (r_y == Y_W'(GRID_H - 1)) begin
                        r_y <= '0;
                        r_x <= r_x + 1'b1;
                    end else begin
                        r_y <= r_y + 1'b1;
                    end
                end
                CNT_STEP_INNER: begin
                    if (r_y == Y_W'(GRID_H - 2)) begin
                        r_y <= Y_W'(1);
                        r_x <= r_x + 1'b1;
                    end else begin
                        r_y <= r_y + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // addresses
    logic [ADDR_W-1:0] here_addr, nb_rd_addr, nb_wr_addr, pos_addr, rd_addr;

    assign here_addr  = cell_addr(r_x, r_y);
    assign nb_rd_addr = nb_addr(r_x, r_y, r_diag, i_cmd.rd_nb);
    assign nb_wr_addr = nb_addr(r_x, r_y, r_diag, i_cmd.wr_nb);
    assign pos_addr   = cell_addr(X_W'(r_in.pos_x), Y_W'(r_in.pos_y));

    always_comb begin
        case (i_cmd.rd_src)
            RD_NB:   rd_addr = nb_rd_addr;
            RD_POS:  rd_addr = pos_addr;
            default: rd_addr = here_addr;
        endcase
    end

    // ink layer memories
    t_rgb r_mem_surf [CELLS];
    t_rgb r_mem_mid  [CELLS];
    t_rgb r_mem_deep [CELLS];
    t_rgb r_rd_surf, r_rd_mid, r_rd_deep;

    t_rgb br_word, upd_mine, upd_oth, fin_surf, fin_mid, fin_deep;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_surf <= r_mem_surf[rd_addr];
            r_rd_mid  <= r_mem_mid[rd_addr];
            r_rd_deep <= r_mem_deep[rd_addr];
        end
        if (i_cmd.clr_wr) begin
            r_mem_surf[here_addr] <= '0;
        end else if (i_cmd.br_wr) begin
            r_mem_surf[here_addr] <= br_word;
        end else if (i_cmd.d_fin) begin
            r_mem_surf[here_addr] <= fin_surf;
        end
        if (i_cmd.clr_wr) begin
            r_mem_mid[here_addr] <= '0;
        end else if (i_cmd.d_upd) begin
            r_mem_mid[nb_wr_addr] <= upd_oth;
        end else if (i_cmd.d_fin) begin
            r_mem_mid[here_addr] <= fin_mid;
        end
        if (i_cmd.clr_wr) begin
            r_mem_deep[here_addr] <= '0;
        end else if (i_cmd.d_fin) begin
            r_mem_deep[here_addr] <= fin_deep;
        end
    end

    // brush: squared distances registered, weighting next cycle
    logic [XD_W-1:0]   dx;
    logic [YD_W-1:0]   dy;
    logic [2*XD_W-1:0] r_dx2;
    logic [2*YD_W-1:0] r_dy2;
    logic [DIST_W-1:0] br_dist;
    logic              hit;

    always_comb begin
        if (XD_W'(r_x) > XD_W'(r_in.pos_x)) begin
            dx = XD_W'(r_x) - XD_W'(r_in.pos_x);
        end else begin
            dx = XD_W'(r_in.pos_x) - XD_W'(r_x);
        end
        if (YD_W'(r_y) > YD_W'(r_in.pos_y)) begin
            dy = YD_W'(r_y) - YD_W'(r_in.pos_y);
        end else begin
            dy = YD_W'(r_in.pos_y) - YD_W'(r_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.br_pre) begin
            r_dx2 <= (2*XD_W)'(dx) * (2*XD_W)'(dx);
            r_dy2 <= (2*YD_W)'(dy) * (2*YD_W)'(dy);
        end
    end

    assign br_dist = DIST_W'(r_dx2) * DIST_W'(r_rxw) + DIST_W'(r_dy2) * DIST_W'(r_ryw);
    assign hit     = br_dist < DIST_W'(r_bound);

    always_comb begin
        br_word = r_rd_surf;
        if (hit && r_pen != PEN_NONE) begin
            br_word[r_pen] = sat_add(r_rd_surf[r_pen], 16'(ink_amount(r_level)));
        end
    end

    // diffusion work registers
    t_rgb r_mine, r_surf, r_deep;
    t_q   thr;

    assign thr = r_wet ? WET_THRESH : DRY_THRESH;

    always_comb begin
        t_q diff;
        t_q half;
        upd_mine = r_mine;
        upd_oth  = r_rd_mid;
        for (int c = 0; c < 3; c++) begin
            diff = r_rd_mid[c] - r_mine[c];
            half = diff >> 1;
            if (r_rd_mid[c] > r_mine[c] && diff > thr) begin
                upd_mine[c] = r_mine[c] + half;
                upd_oth[c]  = r_rd_mid[c] - half;
            end
        end
    end

    always_comb begin
        t_q s;
        t_q m;
        t_q d;
        fin_surf = r_surf;
        fin_mid  = r_mine;
        fin_deep = r_deep;
        for (int c = 0; c < 3; c++) begin
            s = r_surf[c];
            m = r_mine[c];
            d = r_deep[c];
            if (s > SURF_LIMIT) begin
                s = s - SURF_MOVE;
                m = sat_add(m, SURF_MOVE);
            end
            if (m > MID_LIMIT) begin
                m = m - MID_LOSS;
                d = sat_add(d, DEEP_GAIN);
            end
            fin_surf[c] = s;
            fin_mid[c]  = m;
            fin_deep[c] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.d_lat) begin
            r_mine <= r_rd_mid;
            r_surf <= r_rd_surf;
            r_deep <= r_rd_deep;
        end else if (i_cmd.d_upd) begin
            r_mine <= upd_mine;
        end
    end

    // read result and output register
    t_out_item   r_res, r_out, shown;
    logic        r_out_valid;
    logic        in_range;
    logic [12:0] col [3];

    assign in_range = (int'(r_in.pos_x) < GRID_W) && (int'(r_in.pos_y) < GRID_H);

    always_comb begin
        logic [17:0] sum;
        for (int c = 0; c < 3; c++) begin
            sum = 18'(r_rd_surf[c]) + 18'(r_rd_mid[c]) + 18'(r_rd_deep[c]);
            col[c] = (sum >= ONE_Q || !in_range) ? 13'd0 : 13'(ONE_Q - sum);
        end
        shown.shown_red   = col[0];
        shown.shown_green = col[1];
        shown.shown_blue  = col[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_res <= '0;
        end else if (i_cmd.res_load) begin
            r_res <= shown;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_stat.mode       = r_in.mode;
    assign o_stat.paint      = r_in.brush_down && (r_pen != PEN_NONE);
    assign o_stat.full_last  = full_last;
    assign o_stat.inner_last = inner_last;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

`ifndef NO_ASSERTIONS
    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_x) < GRID_W) && (int'(r_y) < GRID_H))
        else $error("scan counter outside grid");

    a_mid_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.d_upd && i_cmd.rd_en) |-> (nb_wr_addr != rd_addr))
        else $error("neighbor write and read hit same cell");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken one");

    a_level_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.frame && r_in.brush_down && r_level > 8'd1)
        |=> (r_level == $past(r_level) - 8'd1))
        else $error("ink level did not drop by one");
`endif

endmodule

FILE: src/watercolor_ink_diffusion_top.sv
// top level of the watercolor ink diffusion block
// One request is taken at a time and gives exactly one result. A clear request
// writes one cell per cycle. A frame request runs a brush pass over the whole
// grid when the brush is down with a valid pen colour, then a diffusion sweep
// over the inner cells. Each diffusion pixel takes seven steps because every
// neighbor's middle layer goes through the single read port and single write
// port of the layer memories one cell at a time. After reset the block clears
// all three layer memories before it takes its first request; configuration
// writes are taken at any time, but only change behavior safely while no
// request is in flight.
module watercolor_ink_diffusion_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wid_pkg::t_in_item  i_in,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wid_pkg::t_out_item o_out,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data
);
    import wid_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // config registers are plain flops, a write always lands
    assign o_cfg_ready = 1'b1;

    // controller: walks clear, brush, diffusion and read sequences
    wid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: layer memories, counters, arithmetic and output register
    wid_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

FILE: tb/watercolor_ink_diffusion_top_test.sv
// self-checking testbench for the watercolor ink diffusion block
module watercolor_ink_diffusion_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wid_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] MODE_IDLE  = 2'd3;
    localparam logic [1:0] PAPER_KEEP = 2'd3;
    localparam logic [2:0] REG_NONE   = 3'd7;

    // ink layers, brush level and registers of the block, predicted in step with it
    class ink_scoreboard;
        bit [15:0] surf [CELLS][3];
        bit [15:0] mid [CELLS][3];
        bit [15:0] deep [CELLS][3];
        bit [7:0] level = 8'd40;
        bit diag = 1'b0;
        bit [1:0] pen = 2'd0;
        bit [7:0] cap = 8'd40;
        bit [4:0] rxw = 5'd15;
        bit [4:0] ryw = 5'd15;
        bit [9:0] size = 10'd40;
        bit [1:0] paper = PAPER_ALT;
        bit wet = 1'b0;
        t_out_item shown_q[$];
        int errors = 0;
        int frames = 0;
        int reads = 0;
        int clears = 0;

        function int pending();
            return shown_q.size();
        endfunction

        function bit [15:0] sat16(int unsigned a, int unsigned b);
            int unsigned s;
            s = a + b;
            return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
        endfunction

        function void write_reg(logic [2:0] idx, logic [9:0] d);
            case (idx)
                REG_PEN:   pen = d[1:0];
                REG_CAP:   cap = d[7:0];
                REG_RXW:   rxw = d[4:0];
                REG_RYW:   ryw = d[4:0];
                REG_SIZE:  size = d;
                REG_PAPER: paper = d[1:0];
                REG_WET:   wet = d[0];
                default: ;
            endcase
        endfunction

        function void wipe();
            for (int i = 0; i < CELLS; i++) begin
                for (int c = 0; c < 3; c++) begin
                    surf[i][c] = '0;
                    mid[i][c] = '0;
                    deep[i][c] = '0;
                end
            end
        endfunction

        function void paint(int unsigned cx, int unsigned cy);
            int unsigned bound, amount, dx, dy, i;
            bound = size * size;
            if (level > 1) level--;
            if (pen == PEN_NONE) return;
            amount = (level * 1024 + 25) / 50;
            for (int unsigned x = 0; x < GRID_W; x++) begin
                dx = (x > cx) ? x - cx : cx - x;
                for (int unsigned y = 0; y < GRID_H; y++) begin
                    dy = (y > cy) ? y - cy : cy - y;
                    if (dx * dx * rxw + dy * dy * ryw < bound) begin
                        i = x + y * GRID_W;
                        surf[i][pen] = sat16(surf[i][pen], amount);
                    end
                end
            end
        endfunction

        function void sweep();
            int unsigned nb[4];
            int unsigned here, thresh, mine, other, half;
            thresh = wet ? 41 : 410;
            for (int unsigned x = 1; x + 1 < GRID_W; x++) begin
                for (int unsigned y = 1; y + 1 < GRID_H; y++) begin
                    here = x + y * GRID_W;
                    if (diag) begin
                        nb[0] = here - GRID_W - 1;
                        nb[1] = here + GRID_W - 1;
                        nb[2] = here - GRID_W + 1;
                        nb[3] = here + GRID_W + 1;
                    end else begin
                        nb[0] = here + 1;
                        nb[1] = here - 1;
                        nb[2] = here + GRID_W;
                        nb[3] = here - GRID_W;
                    end
                    for (int c = 0; c < 3; c++) begin
                        // middle layer pulls half the excess from each neighbor richer by more than the threshold
                        for (int k = 0; k < 4; k++) begin
                            mine = mid[here][c];
                            other = mid[nb[k]][c];
                            if (other > mine && other - mine > thresh) begin
                                half = (other - mine) >> 1;
                                mid[here][c] = 16'(mine + half);
                                mid[nb[k]][c] = 16'(other - half);
                            end
                        end
                        if (surf[here][c] > 819) begin
                            surf[here][c] = surf[here][c] - 16'd123;
                            mid[here][c] = sat16(mid[here][c], 123);
                        end
                        if (mid[here][c] > 410) begin
                            mid[here][c] = mid[here][c] - 16'd41;
                            deep[here][c] = sat16(deep[here][c], 20);
                        end
                    end
                end
            end
        endfunction

        function void note_request(t_in_item it);
            t_out_item r;
            int unsigned i, sum;
            r = '0;
            case (it.mode)
                MODE_FRAME: begin
                    frames++;
                    if (it.brush_down) paint(32'(it.pos_x), 32'(it.pos_y));
                    else level = cap;
                    case (paper)
                        PAPER_CROSS: diag = 1'b0;
                        PAPER_DIAG:  diag = 1'b1;
                        PAPER_ALT:   diag = ~diag;
                        default: ;
                    endcase
                    sweep();
                end
                MODE_READ: begin
                    reads++;
                    i = it.pos_x + it.pos_y * GRID_W;
                    sum = surf[i][0] + mid[i][0] + deep[i][0];
                    r.shown_red = (sum >= 4096) ? '0 : 13'(4096 - sum);
                    sum = surf[i][1] + mid[i][1] + deep[i][1];
                    r.shown_green = (sum >= 4096) ? '0 : 13'(4096 - sum);
                    sum = surf[i][2] + mid[i][2] + deep[i][2];
                    r.shown_blue = (sum >= 4096) ? '0 : 13'(4096 - sum);
                end
                MODE_CLEAR: begin
                    clears++;
                    wipe();
                end
                default: ;
            endcase
            shown_q.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (shown_q.size() == 0) begin
                $display("%0t: result with none expected: %h", $realtime, got);
                errors++;
                return;
            end
            want = shown_q.pop_front();
            if (got.shown_red !== want.shown_red) begin
                $display("%0t: red expected %0d actual %0d", $realtime,
                         want.shown_red, got.shown_red);
                errors++;
            end
            if (got.shown_green !== want.shown_green) begin
                $display("%0t: green expected %0d actual %0d", $realtime,
                         want.shown_green, got.shown_green);
                errors++;
            end
            if (got.shown_blue !== want.shown_blue) begin
                $display("%0t: blue expected %0d actual %0d", $realtime,
                         want.shown_blue, got.shown_blue);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;

    ink_scoreboard sb = new();

    // receiver control: quiet disables stalls, hold_request asks for one long hold
    bit quiet = 1'b0;
    int hold_request = 0;
    int hold_left = 0;
    int stall_left = 0;

    // painting center of the latest brush-down frame, reads cluster around it
    int unsigned spot_x = 128;
    int unsigned spot_y = 128;

    watercolor_ink_diffusion_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // watch all three channels at each edge, values seen are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready) sb.note_request(in_item);
            if (out_valid && out_ready) sb.check_result(out_item);
        end
    end

    // result side: short stalls now and then, a few long ones, one forced hold
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(1, 3);
        end
    end

    // overall watchdog, frames are long so this is loose
    initial begin
        #400_000_000;
        $display("watercolor_ink_diffusion_top_test NOT OK");
        $finish;
    end

    function int pick_gap();
        if (quiet) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
        return $urandom_range(0, 2);
    endfunction

    // offer one request after an optional gap, return at its accepting edge
    task automatic push_request(t_in_item it, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic send(logic [1:0] mode, logic down, logic [7:0] x, logic [7:0] y);
        t_in_item it;
        it.mode = mode;
        it.brush_down = down;
        it.pos_x = x;
        it.pos_y = y;
        if (mode == MODE_FRAME && down) begin
            spot_x = x;
            spot_y = y;
        end
        push_request(it, pick_gap());
    endtask

    // let every result arrive, then a short settle before touching registers
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [9:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [9:0] pen, logic [9:0] cap, logic [9:0] rx,
                             logic [9:0] ry, logic [9:0] sz, logic [9:0] pm,
                             logic [9:0] wt);
        write_reg(REG_PEN, pen);
        write_reg(REG_CAP, cap);
        write_reg(REG_RXW, rx);
        write_reg(REG_RYW, ry);
        write_reg(REG_SIZE, sz);
        write_reg(REG_PAPER, pm);
        write_reg(REG_WET, wt);
    endtask

    task automatic read_near(int n);
        for (int k = 0; k < n; k++)
            send(MODE_READ, 1'($urandom), 8'(spot_x + $urandom_range(0, 40) - 20),
                 8'(spot_y + $urandom_range(0, 40) - 20));
    endtask

    initial begin
        int frames_left;
        int clears_left;
        int roll;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: grid corners, idle mode, clear, painting with alternating paper
        quiet = 1'b1;
        send(MODE_READ, 1'b0, 8'd0, 8'd0);
        send(MODE_READ, 1'b1, 8'd255, 8'd255);
        send(MODE_IDLE, 1'b1, 8'd255, 8'd0);
        send(MODE_CLEAR, 1'b0, 8'd0, 8'd255);
        quiet = 1'b0;
        send(MODE_FRAME, 1'b1, 8'd128, 8'd128);
        send(MODE_FRAME, 1'b1, 8'd130, 8'd126);
        read_near(3);
        send(MODE_FRAME, 1'b0, 8'd0, 8'd0);
        send(MODE_READ, 1'b0, 8'd128, 8'd128);
        drain();

        // wide flat brush in blue on wet diagonal paper, capacity of one
        write_all(10'd2, 10'd1, 10'd1, 10'd31, 10'd1023, 10'(PAPER_DIAG), 10'd1);
        write_reg(REG_NONE, 10'h3FF);
        send(MODE_FRAME, 1'b0, 8'd0, 8'd255);
        send(MODE_FRAME, 1'b1, 8'd0, 8'd255);
        read_near(3);
        send(MODE_READ, 1'b0, 8'd255, 8'd0);
        drain();

        // no pen, tiny brush, cross paper, full capacity
        write_all(10'(PEN_NONE), 10'd255, 10'd31, 10'd1, 10'd5, 10'(PAPER_CROSS), 10'd0);
        send(MODE_FRAME, 1'b1, 8'd255, 8'd0);
        send(MODE_READ, 1'b0, 8'd1, 8'd1);
        drain();

        // green, empty capacity, pattern frozen, medium ellipse
        write_all(10'd1, 10'd0, 10'd0, 10'd0, 10'd200, 10'(PAPER_KEEP), 10'd1);
        write_reg(REG_RXW, 10'd7);
        write_reg(REG_RYW, 10'd29);
        send(MODE_FRAME, 1'b0, 8'd60, 8'd190);
        send(MODE_FRAME, 1'b1, 8'd60, 8'd190);
        read_near(2);
        drain();

        // random part, mostly reads, a few frames and at most one clear
        write_all(10'd0, 10'd120, 10'd3, 10'd5, 10'd60, 10'(PAPER_ALT), 10'd0);
        frames_left = 3;
        clears_left = 1;
        for (int n = 0; n < 75; n++) begin
            if (n == 30) begin
                // block the result side while requests keep coming
                hold_request = 300;
                for (int k = 0; k < 6; k++) begin
                    t_in_item it;
                    it.mode = MODE_READ;
                    it.brush_down = 1'($urandom);
                    it.pos_x = 8'($urandom);
                    it.pos_y = 8'($urandom);
                    push_request(it, 0);
                end
                drain();
            end
            quiet = (n >= 50 && n < 60);
            roll = $urandom_range(0, 99);
            if (roll < 5 && frames_left > 0) begin
                frames_left--;
                send(MODE_FRAME, 1'($urandom_range(0, 3) != 0), 8'($urandom), 8'($urandom));
            end else if (roll < 7 && clears_left > 0) begin
                clears_left--;
                send(MODE_CLEAR, 1'($urandom), 8'($urandom), 8'($urandom));
            end else if (roll < 15) begin
                send(MODE_IDLE, 1'($urandom), 8'($urandom), 8'($urandom));
            end else if (roll < 60) begin
                read_near(1);
            end else begin
                send(MODE_READ, 1'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        quiet = 1'b0;
        drain();
        repeat (50) @(posedge i_clk);

        $display("covered %0d frames, %0d reads, %0d clears under five register settings",
                 sb.frames, sb.reads, sb.clears);
        $display("mismatches %0d, results still owed %0d", sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("watercolor_ink_diffusion_top_test OK");
        end else begin
            $display("watercolor_ink_diffusion_top_test NOT OK");
        end
        $finish;
    end
endmodule
